/* rtl/bdcc_pkg.sv */
package bdcc_pkg;

   // Width of the internal time base; timestamps wrap modulo 2^TIME_WIDTH.
   localparam int TIME_WIDTH = 32;

   // Width of the timestamp field on the input channel.
   localparam int STAMP_WIDTH = 32;

   // Width of the timeout configuration registers.
   localparam int TIMEOUT_WIDTH = 32;

   typedef logic [TIME_WIDTH-1:0] time_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_INVERSE_POLARITY     = 2'd0,
      CSR_BOUNCE_TIMEOUT       = 2'd1,
      CSR_DOUBLE_CLICK_TIMEOUT = 2'd2
   } csr_index_type;

   localparam logic [TIMEOUT_WIDTH-1:0] BOUNCE_TIMEOUT_RESET       = 32'd50000;
   localparam logic [TIMEOUT_WIDTH-1:0] DOUBLE_CLICK_TIMEOUT_RESET = 32'd300000;

   // Event codes on the result channel.
   typedef enum logic [1:0] {
      EV_PRESS   = 2'd0,
      EV_RELEASE = 2'd1,
      EV_CLICK   = 2'd2,
      EV_DOUBLE  = 2'd3
   } event_type;

   // Configuration as seen by the classifier.
   typedef struct packed {
      logic                     inverse_polarity;
      logic [TIMEOUT_WIDTH-1:0] bounce_timeout;
      logic [TIMEOUT_WIDTH-1:0] double_click_timeout;
   } cfg_type;

   // Outcome of classifying one sample: how many events and which.
   typedef struct packed {
      logic [1:0] event_count;
      event_type  first_code;
      event_type  second_code;
   } decision_type;

   // Fit a 32-bit value into the time base: truncate or zero-extend.
   function automatic time_type to_time(input logic [STAMP_WIDTH-1:0] value);
      time_type result;
      result = '0;
      for (int i = 0; i < TIME_WIDTH && i < STAMP_WIDTH; i++) begin
         result[i] = value[i];
      end
      return result;
   endfunction

endpackage

/* rtl/bdcc_classify.sv */
module bdcc_classify (
   input  logic                  clock,
   input  logic                  reset,
   input  bdcc_pkg::cfg_type     cfg,
   input  logic                  level,
   input  bdcc_pkg::time_type    now,
   input  logic                  consume,
   output bdcc_pkg::decision_type decision
);
   import bdcc_pkg::*;

   logic     raw_level_ff;
   time_type last_change_time_ff;
   time_type last_click_time_ff;

   time_type change_delta;
   time_type click_delta;
   logic     bounce;
   logic     change_taken;
   logic     pressed;
   logic     quick_repeat;

   // Elapsed times wrap modulo the time base.
   assign change_delta = now - last_change_time_ff;
   assign click_delta  = now - last_click_time_ff;
   assign bounce       = change_delta < to_time(cfg.bounce_timeout);
   assign quick_repeat = click_delta < to_time(cfg.double_click_timeout);
   assign change_taken = !bounce && (raw_level_ff != level);
   assign pressed      = level ^ cfg.inverse_polarity;

   // A release yields one event, a press yields press plus click or double click.
   always_comb begin
      decision.event_count = 2'd0;
      decision.first_code  = EV_RELEASE;
      decision.second_code = quick_repeat ? EV_DOUBLE : EV_CLICK;
      if (change_taken) begin
         if (pressed) begin
            decision.event_count = 2'd2;
            decision.first_code  = EV_PRESS;
         end else begin
            decision.event_count = 2'd1;
         end
      end
   end

   // Debounce state advances once per consumed sample.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff        <= 1'b0;
         last_change_time_ff <= '0;
         last_click_time_ff  <= '0;
      end else if (consume) begin
         raw_level_ff <= level;
         if (change_taken) begin
            last_change_time_ff <= now;
            if (pressed) begin
               last_click_time_ff <= now;
            end
         end
      end
   end

endmodule

/* rtl/button_debounce_click_classifier.sv */
// Button debounce and click classifier. Each request beat is one pin-change
// sample (raw level and wrapping microsecond timestamp). Changes closer than
// the bounce timeout to the last accepted change, or that do not change the
// level, produce no event. An accepted release produces RELEASE; an accepted
// press produces PRESS followed by CLICK, or DOUBLE when it comes within
// the double-click timeout of the previous click. rsp_tlast marks the final
// event of a sample. Each sample is held in the input register, classified
// and its first event registered. A new sample can be taken every cycle
// while samples produce at most one event and the result channel is ready;
// a press occupies the single result port for two beats, so the next sample
// waits for the second to leave. Configuration writes are accepted every
// cycle and must be made while no sample is in flight.
module button_debounce_click_classifier (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [0] level, [32:1] time_us, rest zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] event_code, rest zero
   output logic        rsp_tlast,   // last_of_run
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import bdcc_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff;
   logic         in_level_ff;
   time_type     in_time_ff;
   decision_type decision;
   logic         out_free;
   logic         consume;
   logic         rsp_valid_ff;
   event_type    rsp_code_ff;
   logic         rsp_last_ff;
   logic         pend_valid_ff;
   event_type    pend_code_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.inverse_polarity     <= 1'b0;
         cfg_ff.bounce_timeout       <= BOUNCE_TIMEOUT_RESET;
         cfg_ff.double_click_timeout <= DOUBLE_CLICK_TIMEOUT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INVERSE_POLARITY:     cfg_ff.inverse_polarity     <= csr_data[0];
            CSR_BOUNCE_TIMEOUT:       cfg_ff.bounce_timeout       <= csr_data;
            CSR_DOUBLE_CLICK_TIMEOUT: cfg_ff.double_click_timeout <= csr_data;
            default: ;
         endcase
      end
   end

   // The result stage can take new events when nothing is pending and the
   // current beat is empty or leaving.
   assign out_free   = !pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign consume    = in_valid_ff && ((decision.event_count == 2'd0) || out_free);
   assign req_tready = !in_valid_ff || consume;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_level_ff <= req_tdata[0];
         in_time_ff  <= to_time(req_tdata[STAMP_WIDTH:1]);
      end
   end

   bdcc_classify u_classify (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .level    (in_level_ff),
      .now      (in_time_ff),
      .consume  (consume),
      .decision (decision)
   );

   // Result register plus one pending slot for the second event of a press.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (consume && (decision.event_count != 2'd0)) begin
         rsp_valid_ff  <= 1'b1;
         pend_valid_ff <= (decision.event_count == 2'd2);
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_ff  <= pend_valid_ff;
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (consume && (decision.event_count != 2'd0)) begin
         rsp_code_ff  <= decision.first_code;
         rsp_last_ff  <= (decision.event_count == 2'd1);
         pend_code_ff <= decision.second_code;
      end else if (rsp_valid_ff && rsp_tready && pend_valid_ff) begin
         rsp_code_ff <= pend_code_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
